// File: rtl/q4bd_pkg.sv
// Shared constants for the 4-bit block dequantisation dot product.
// Used by q4bd_accum, q4bd_scale and q4_block_dequant_dot; no dependencies.
package q4bd_pkg;

    localparam int DEF_BLOCK_BYTES = 16;
    localparam int DEF_ACT_BITS    = 16;

    localparam int WEIGHT_BITS = 8;
    localparam int NIBBLE_BITS = 4;
    localparam int SCALE_BITS  = 16;
    localparam int OUT_BITS    = 40;

    // Stored nibbles carry an offset of eight; subtracting it gives -8..7.
    localparam logic signed [NIBBLE_BITS:0] NIBBLE_OFFSET = 5'sd8;

endpackage

// File: rtl/q4bd_accum.sv
// Input register, nibble decode, two small multiplies and the block accumulator.
// Depends on q4bd_pkg. Hands the finished block sum to q4bd_scale.
module q4bd_accum #(
    parameter int BLOCK_BYTES = q4bd_pkg::DEF_BLOCK_BYTES,
    parameter int ACT_BITS    = q4bd_pkg::DEF_ACT_BITS,
    parameter int SUM_W       = ACT_BITS + 5 + $clog2(BLOCK_BYTES)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [q4bd_pkg::WEIGHT_BITS-1:0]      i_weights,
    input  logic signed [ACT_BITS-1:0]            i_act_even,
    input  logic signed [ACT_BITS-1:0]            i_act_odd,
    input  logic signed [q4bd_pkg::SCALE_BITS-1:0] i_scale,
    output logic                                  o_fin_valid,
    input  logic                                  i_fin_ready,
    output logic signed [SUM_W-1:0]               o_fin_sum,
    output logic signed [q4bd_pkg::SCALE_BITS-1:0] o_fin_scale
);
    import q4bd_pkg::*;

    localparam int CNT_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int PROD_W = ACT_BITS + NIBBLE_BITS + 1;

    logic                          r_in_valid;
    logic [WEIGHT_BITS-1:0]        r_weights;
    logic signed [ACT_BITS-1:0]    r_act_even;
    logic signed [ACT_BITS-1:0]    r_act_odd;
    logic signed [SCALE_BITS-1:0]  r_scale;
    logic signed [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]              r_cnt;

    logic signed [NIBBLE_BITS:0]   w_lo;
    logic signed [NIBBLE_BITS:0]   w_hi;
    logic signed [PROD_W-1:0]      p_lo;
    logic signed [PROD_W-1:0]      p_hi;
    logic signed [SUM_W-1:0]       n_sum;
    logic                          last;
    logic                          consume;

    always_comb begin
        w_lo    = $signed({1'b0, r_weights[NIBBLE_BITS-1:0]}) - NIBBLE_OFFSET;
        w_hi    = $signed({1'b0, r_weights[WEIGHT_BITS-1:NIBBLE_BITS]}) - NIBBLE_OFFSET;
        p_lo    = PROD_W'(w_lo) * PROD_W'(r_act_even);
        p_hi    = PROD_W'(w_hi) * PROD_W'(r_act_odd);
        n_sum   = r_sum + SUM_W'(p_lo) + SUM_W'(p_hi);
        last    = (r_cnt == CNT_W'(BLOCK_BYTES - 1));
        // A byte that closes the block leaves only when the scaling stage has room.
        consume = r_in_valid && (!last || i_fin_ready);
    end

    assign o_ready     = !r_in_valid || consume;
    assign o_fin_valid = r_in_valid && last;
    assign o_fin_sum   = n_sum;
    assign o_fin_scale = r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_sum      <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                if (last) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_weights  <= i_weights;
            r_act_even <= i_act_even;
            r_act_odd  <= i_act_odd;
            r_scale    <= i_scale;
        end
    end

endmodule

// File: rtl/q4bd_scale.sv
// Block sum register, scale multiply and the result register.
// Depends on q4bd_pkg; fed by q4bd_accum.
module q4bd_scale #(
    parameter int SUM_W = 25
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_fin_valid,
    output logic                                   o_fin_ready,
    input  logic signed [SUM_W-1:0]                i_fin_sum,
    input  logic signed [q4bd_pkg::SCALE_BITS-1:0] i_fin_scale,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [q4bd_pkg::OUT_BITS-1:0]          o_data
);
    import q4bd_pkg::*;

    localparam int PROD_W = SUM_W + SCALE_BITS;
    localparam int EXT_W  = (PROD_W > OUT_BITS) ? PROD_W : OUT_BITS;

    logic                          r_f_valid;
    logic signed [SUM_W-1:0]       r_f_sum;
    logic signed [SCALE_BITS-1:0]  r_f_scale;
    logic                          r_out_valid;
    logic [OUT_BITS-1:0]           r_out_data;

    logic signed [PROD_W-1:0]      product;
    logic signed [EXT_W-1:0]       product_ext;
    logic                          load_out;

    always_comb begin
        product     = PROD_W'(r_f_sum) * PROD_W'(r_f_scale);
        product_ext = EXT_W'(product);
        load_out    = r_f_valid && (!r_out_valid || i_ready);
    end

    assign o_fin_ready = !r_f_valid || load_out;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_fin_valid && o_fin_ready) begin
                r_f_valid <= 1'b1;
            end else if (load_out) begin
                r_f_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_valid && o_fin_ready) begin
            r_f_sum   <= i_fin_sum;
            r_f_scale <= i_fin_scale;
        end
        if (load_out) begin
            r_out_data <= product_ext[OUT_BITS-1:0];
        end
    end

endmodule

// File: rtl/q4_block_dequant_dot.sv
// Top level of the 4-bit block dequantisation dot product.
// Depends on q4bd_pkg, q4bd_accum and q4bd_scale.
//
// Each input transfer carries one packed weight byte (two 4-bit weights stored
// with an offset of eight), the even and odd activations that pair with its low
// and high nibble, and the block scale, all signed Q4.12 at the default width.
// The block keeps an exact integer sum of weight times activation over
// BLOCK_BYTES transfers; on the last byte of a block it multiplies that sum by
// the scale carried with that byte and emits one Q16.24 result of 40 bits,
// wrapping modulo 2^40 only if the parameters are raised beyond what 40 bits
// hold. Scales on other bytes are ignored, and the sum and byte count restart
// at zero after each block. A new transfer is accepted in every cycle, except
// while a closing byte waits for the block sum register to free up: the
// input register feeds the two nibble multiplies and the accumulator, the
// finished block sum is registered, and the scale multiply fills the result
// register. A result thus passes through the input, block sum and result
// registers; bytes that do not close a block keep flowing while a result waits.
module q4_block_dequant_dot #(
    parameter int BLOCK_BYTES = q4bd_pkg::DEF_BLOCK_BYTES,
    parameter int ACT_BITS    = q4bd_pkg::DEF_ACT_BITS,
    localparam int IN_BITS    = q4bd_pkg::WEIGHT_BITS + 2 * ACT_BITS
                                + q4bd_pkg::SCALE_BITS,
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((q4bd_pkg::OUT_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // packed_weights, act_even, act_odd, block_scale, then zero fill
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // block_dot, then zero fill
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);
    import q4bd_pkg::*;

    // Wide enough for the largest possible sum of one block, kept exactly.
    localparam int SUM_W = ACT_BITS + 5 + $clog2(BLOCK_BYTES);

    localparam int AE_LO = WEIGHT_BITS;
    localparam int AO_LO = AE_LO + ACT_BITS;
    localparam int SC_LO = AO_LO + ACT_BITS;

    logic                          fin_valid;
    logic                          fin_ready;
    logic signed [SUM_W-1:0]       fin_sum;
    logic signed [SCALE_BITS-1:0]  fin_scale;
    logic [OUT_BITS-1:0]           out_data;

    q4bd_accum #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .ACT_BITS    (ACT_BITS),
        .SUM_W       (SUM_W)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_weights   (i_s_axis_tdata[WEIGHT_BITS-1:0]),
        .i_act_even  ($signed(i_s_axis_tdata[AE_LO +: ACT_BITS])),
        .i_act_odd   ($signed(i_s_axis_tdata[AO_LO +: ACT_BITS])),
        .i_scale     ($signed(i_s_axis_tdata[SC_LO +: SCALE_BITS])),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin_sum   (fin_sum),
        .o_fin_scale (fin_scale)
    );

    q4bd_scale #(
        .SUM_W       (SUM_W)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .o_fin_ready (fin_ready),
        .i_fin_sum   (fin_sum),
        .i_fin_scale (fin_scale),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (out_data)
    );

    // Any padding bits of the result bus read as zero.
    assign o_m_axis_tdata = M_TDATA_W'(out_data);

endmodule

// File: sim/q4bd_dot_checker.sv
// Checker for the 4-bit block dequantisation dot product: watches both stream
// channels, predicts each block result and compares it. Depends on q4bd_pkg.
module q4bd_dot_checker #(
    parameter int S_W = 56,
    parameter int M_W = 40
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    input  logic           i_s_axis_tready,
    input  logic [S_W-1:0] i_s_axis_tdata,
    input  logic           i_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    input  logic [M_W-1:0] i_m_axis_tdata,
    output int             o_fail_count,
    output int             o_blocks_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import q4bd_pkg::*;

    // One input byte as it sits in tdata, lowest field last in this list.
    typedef struct packed {
        logic signed [SCALE_BITS-1:0]   block_scale;
        logic signed [DEF_ACT_BITS-1:0] act_odd;
        logic signed [DEF_ACT_BITS-1:0] act_even;
        logic [WEIGHT_BITS-1:0]         packed_weights;
    } t_weight_byte;

    longint                dot_acc = 0;
    int                    bytes_in_block = 0;
    int                    blocks_seen = 0;
    int                    fails = 0;
    logic [OUT_BITS-1:0]   block_dot_q[$];

    // Stored nibbles carry an offset of eight.
    function automatic longint nibble_weight(input logic [NIBBLE_BITS-1:0] nib);
        return longint'(nib) - longint'(NIBBLE_OFFSET);
    endfunction

    always @(posedge i_clk) begin
        t_weight_byte        wb;
        logic [OUT_BITS-1:0] want;
        logic [OUT_BITS-1:0] got;
        longint              scaled;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                wb = t_weight_byte'(i_s_axis_tdata[$bits(t_weight_byte)-1:0]);
                dot_acc = dot_acc
                    + nibble_weight(wb.packed_weights[NIBBLE_BITS-1:0])
                      * longint'(wb.act_even)
                    + nibble_weight(wb.packed_weights[WEIGHT_BITS-1:NIBBLE_BITS])
                      * longint'(wb.act_odd);
                bytes_in_block++;
                if (bytes_in_block == DEF_BLOCK_BYTES) begin
                    // Only the scale of the closing byte counts.
                    scaled = dot_acc * longint'(wb.block_scale);
                    block_dot_q.push_back(scaled[OUT_BITS-1:0]);
                    dot_acc        = 0;
                    bytes_in_block = 0;
                end
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[OUT_BITS-1:0];
                if (block_dot_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("block %0d: block_dot %0d arrived with none due",
                                 blocks_seen, $signed(got));
                end else begin
                    want = block_dot_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("block %0d: block_dot expected %0d, got %0d",
                                     blocks_seen, $signed(want), $signed(got));
                    end
                end
                blocks_seen++;
            end
        end
        o_fail_count     <= fails;
        o_blocks_pending <= block_dot_q.size();
    end

endmodule

// File: sim/tb.sv
// Testbench top for q4_block_dequant_dot: drives the input stream and the
// result back-pressure, and gives the verdict. Depends on q4bd_pkg,
// q4bd_dot_checker and the block itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import q4bd_pkg::*;

    localparam int IN_W    = WEIGHT_BITS + 2 * DEF_ACT_BITS + SCALE_BITS;
    localparam int S_W     = ((IN_W + 7) / 8) * 8;
    localparam int M_W     = ((OUT_BITS + 7) / 8) * 8;
    localparam int N_RAND  = 1600;
    localparam int LIMIT   = 200000;

    localparam logic [15:0] Q_MIN = 16'h8000;
    localparam logic [15:0] Q_MAX = 16'h7FFF;

    // Kinds of block content used by the random part.
    typedef enum int {
        BLK_RANDOM,
        BLK_MAX_POS,   // weights -8 against the most negative activations
        BLK_MAX_NEG,   // weights 7 against the most negative activations
        BLK_ZERO_W     // all nibbles at the offset, so every weight is zero
    } t_block_kind;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_s_axis_tvalid = 1'b0;
    logic           o_s_axis_tready;
    // packed_weights, act_even, act_odd, block_scale, from bit 0 up
    logic [S_W-1:0] i_s_axis_tdata = '0;
    logic           o_m_axis_tvalid;
    logic           i_m_axis_tready = 1'b0;
    // block_dot, from bit 0 up
    logic [M_W-1:0] o_m_axis_tdata;

    int fail_count;
    int blocks_pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;

    q4_block_dequant_dot u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    q4bd_dot_checker #(.S_W(S_W), .M_W(M_W)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .i_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .i_m_axis_tdata   (o_m_axis_tdata),
        .o_fail_count     (fail_count),
        .o_blocks_pending (blocks_pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The result side stalls at random, at whatever rate the current phase
    // of the stimulus has chosen.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Guard against a hung run: the slowest correct run needs well under a
    // tenth of this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Presents one byte and holds it until its transfer. It is entered just
    // after a rising edge, and it returns just after the edge of the transfer,
    // with tvalid still high so that the next byte can follow without a gap.
    task automatic send_byte(input logic [7:0] weights, input logic [15:0] act_even,
                             input logic [15:0] act_odd, input logic [15:0] scale);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_W'({scale, act_odd, act_even, weights});
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        bytes_sent++;
    endtask

    // A 16-bit field that lands on either extreme now and then.
    function automatic logic [15:0] pick_q412();
        case ($urandom_range(7))
            0:       return Q_MIN;
            1:       return Q_MAX;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_block_kind kind;
        logic [7:0]  weights;
        logic [15:0] a_even;
        logic [15:0] a_odd;
        logic [15:0] scale;
        bit          closing;

        kind = BLK_RANDOM;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening. The first block is the largest positive sum
        // possible, scaled by the most negative scale on its closing byte; the
        // scales on the other bytes are at the opposite extreme and must be
        // ignored.
        for (int k = 0; k < DEF_BLOCK_BYTES; k++)
            send_byte(8'h00, Q_MIN, Q_MIN,
                      (k == DEF_BLOCK_BYTES - 1) ? Q_MIN : Q_MAX);
        // Half a block of mixed extremes: weights of 7 and -8 in either nibble,
        // zero weights, and zero scale, none of which closes a block.
        send_byte(8'hFF, Q_MAX, Q_MAX, 16'h0000);
        send_byte(8'h0F, Q_MIN, Q_MAX, 16'h0000);
        send_byte(8'hF0, Q_MAX, Q_MIN, Q_MAX);
        send_byte(8'h88, Q_MIN, Q_MIN, Q_MIN);
        send_byte(8'h80, 16'h0001, 16'hFFFF, 16'h0001);
        send_byte(8'h08, 16'hFFFF, 16'h0001, 16'hFFFF);
        send_byte(8'h7F, 16'h0000, Q_MAX, 16'h1000);
        send_byte(8'hF7, Q_MAX, 16'h0000, 16'hF000);

        // Random part in four phases of back-pressure and source gaps. The
        // content is chosen per block so that extreme sums reach the scale
        // multiply too, not only extreme single bytes.
        for (int n = 0; n < N_RAND; n++) begin
            case (n / (N_RAND / 4))
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (bytes_sent % DEF_BLOCK_BYTES == 0) begin
                case ($urandom_range(9))
                    0:       kind = BLK_MAX_POS;
                    1:       kind = BLK_MAX_NEG;
                    2:       kind = BLK_ZERO_W;
                    default: kind = BLK_RANDOM;
                endcase
            end
            closing = (bytes_sent % DEF_BLOCK_BYTES == DEF_BLOCK_BYTES - 1);
            case (kind)
                BLK_MAX_POS: begin weights = 8'h00; a_even = Q_MIN; a_odd = Q_MIN; end
                BLK_MAX_NEG: begin weights = 8'hFF; a_even = Q_MIN; a_odd = Q_MIN; end
                BLK_ZERO_W:  begin weights = 8'h88; a_even = pick_q412(); a_odd = pick_q412(); end
                default: begin
                    weights = 8'($urandom);
                    a_even  = pick_q412();
                    a_odd   = pick_q412();
                end
            endcase
            // Scales on bytes that do not close a block are pure noise; on the
            // closing byte they favour the extremes and zero.
            scale = 16'($urandom);
            if (closing) begin
                case ($urandom_range(5))
                    0:       scale = Q_MIN;
                    1:       scale = Q_MAX;
                    2:       scale = 16'h0000;
                    default: scale = 16'($urandom);
                endcase
            end
            send_byte(weights, a_even, a_odd, scale);
        end
        i_s_axis_tvalid <= 1'b0;

        // Let every predicted block result arrive, then allow a little longer
        // for anything spurious to show itself.
        do @(posedge i_clk); while (blocks_pending != 0);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && blocks_pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/q4bd_pkg.sv
rtl/q4bd_accum.sv
rtl/q4bd_scale.sv
rtl/q4_block_dequant_dot.sv
sim/q4bd_dot_checker.sv
sim/tb.sv
